/* rtl/bchpe_pkg.sv */
// ----------------------------------------------------------------------------
// bchpe_pkg
// Shared constants, types and elaboration-time generator polynomial math for
// the binary BCH parity encoder over GF(2^13).
// ----------------------------------------------------------------------------
package bchpe_pkg;

  localparam int FieldDegree    = 13;
  localparam logic [FieldDegree:0] GfPoly = 14'h201b;
  localparam int LowStrength    = 4;
  localparam int MaxStrengthDef = 8;
  localparam int MaxDeg         = FieldDegree * MaxStrengthDef;
  localparam int QueueDepth     = 2;

  typedef enum logic {
    StrLow  = 1'b0,
    StrHigh = 1'b1
  } strength_e;

  // Multiply two field elements, shift and add with reduction.
  function automatic logic [FieldDegree-1:0] gf_mul(logic [FieldDegree-1:0] a,
                                                    logic [FieldDegree-1:0] b);
    logic [FieldDegree-1:0] acc;
    logic [FieldDegree-1:0] sh;
    acc = '0;
    sh  = a;
    for (int i = 0; i < FieldDegree; i++) begin
      if (b[i]) begin
        acc = acc ^ sh;
      end
      if (sh[FieldDegree-1]) begin
        sh = {sh[FieldDegree-2:0], 1'b0} ^ GfPoly[FieldDegree-1:0];
      end else begin
        sh = {sh[FieldDegree-2:0], 1'b0};
      end
    end
    return acc;
  endfunction

  // Minimal polynomial of alpha^e: product of (x + r) over the conjugates of
  // alpha^e. Every cyclotomic coset of a nonzero exponent has FieldDegree members.
  function automatic logic [FieldDegree:0] min_poly(int e);
    logic [FieldDegree-1:0] c [FieldDegree+1];
    logic [FieldDegree-1:0] r;
    logic [FieldDegree:0]   mp;
    for (int k = 0; k <= FieldDegree; k++) begin
      c[k] = '0;
    end
    c[0] = FieldDegree'(1);
    r = FieldDegree'(1);
    for (int i = 0; i < e; i++) begin
      r = gf_mul(r, FieldDegree'(2));
    end
    for (int j = 0; j < FieldDegree; j++) begin
      for (int k = FieldDegree; k >= 1; k--) begin
        c[k] = c[k-1] ^ gf_mul(c[k], r);
      end
      c[0] = gf_mul(c[0], r);
      r = gf_mul(r, r);
    end
    for (int k = 0; k <= FieldDegree; k++) begin
      mp[k] = c[k][0];
    end
    return mp;
  endfunction

  // Generator polynomial for correction strength t, without its leading term.
  function automatic logic [MaxDeg-1:0] gen_poly(int t);
    logic [MaxDeg:0]      g;
    logic [MaxDeg:0]      prod;
    logic [FieldDegree:0] m;
    logic [MaxDeg-1:0]    res;
    g = (MaxDeg+1)'(1);
    for (int i = 0; i < t; i++) begin
      m    = min_poly(2 * i + 1);
      prod = '0;
      for (int k = 0; k <= FieldDegree; k++) begin
        if (m[k]) begin
          prod = prod ^ (g << k);
        end
      end
      g = prod;
    end
    for (int k = 0; k < MaxDeg; k++) begin
      res[k] = (k < FieldDegree * t) ? g[k] : 1'b0;
    end
    return res;
  endfunction

endpackage

/* rtl/bchpe_front.sv */
// ----------------------------------------------------------------------------
// bchpe_front
// Input side: holds the strength register and the byte-wide LFSR remainder,
// and hands the finished remainder of each message to the queue.
// ----------------------------------------------------------------------------
module bchpe_front #(
  parameter int MaxStrength = bchpe_pkg::MaxStrengthDef,
  parameter int ShiftW      = ((bchpe_pkg::FieldDegree * MaxStrength + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_data_i,
  input  logic                  in_last_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output logic [ShiftW-1:0]     push_parity_o,
  output bchpe_pkg::strength_e  push_strength_o
);

  localparam int RemW = bchpe_pkg::FieldDegree * MaxStrength;
  localparam int LoW  = bchpe_pkg::FieldDegree * bchpe_pkg::LowStrength;

  // The low-strength remainder sits in the top bits so both modes share one
  // feedback tap at the MSB.
  localparam logic [RemW-1:0] GenHi = RemW'(bchpe_pkg::gen_poly(MaxStrength));
  localparam logic [RemW-1:0] GenLo =
      RemW'(bchpe_pkg::gen_poly(bchpe_pkg::LowStrength)) << (RemW - LoW);

  bchpe_pkg::strength_e strength_q;
  logic [RemW-1:0]      rem_q, rem_d;
  logic [RemW-1:0]      step;
  logic [RemW-1:0]      gen_sel;
  logic                 fb;
  logic                 accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign gen_sel    = (strength_q == bchpe_pkg::StrHigh) ? GenHi : GenLo;

  always_comb begin
    step = rem_q;
    fb   = 1'b0;
    for (int b = 0; b < 8; b++) begin
      fb   = step[RemW-1] ^ in_data_i[7-b];
      step = {step[RemW-2:0], 1'b0};
      if (fb) begin
        step = step ^ gen_sel;
      end
    end
  end

  always_comb begin
    rem_d = rem_q;
    if (cfg_we_i) begin
      rem_d = '0;
    end else if (accept) begin
      rem_d = in_last_i ? '0 : step;
    end
  end

  assign push_valid_o    = accept && in_last_i;
  assign push_parity_o   = ShiftW'(step) << (ShiftW - RemW);
  assign push_strength_o = strength_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= bchpe_pkg::StrLow;
      rem_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        strength_q <= bchpe_pkg::strength_e'(cfg_wdata_i);
      end
      rem_q <= rem_d;
    end
  end

endmodule

/* rtl/bchpe_queue.sv */
// ----------------------------------------------------------------------------
// bchpe_queue
// Short register queue of finished remainders between input and output side.
// ----------------------------------------------------------------------------
module bchpe_queue #(
  parameter int Width = 105
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [Width-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [Width-1:0] rd_data_o
);

  localparam int Depth = bchpe_pkg::QueueDepth;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign wr_ready_o = (count_q != CntW'(Depth));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/bchpe_back.sv */
// ----------------------------------------------------------------------------
// bchpe_back
// Output side: takes one remainder from the queue and shifts it out as
// parity bytes, MSB first, flagging the final byte.
// ----------------------------------------------------------------------------
module bchpe_back #(
  parameter int MaxStrength = bchpe_pkg::MaxStrengthDef,
  parameter int ShiftW      = ((bchpe_pkg::FieldDegree * MaxStrength + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  logic [ShiftW-1:0]    pop_parity_i,
  input  bchpe_pkg::strength_e pop_strength_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_data_o,
  output logic                 out_last_o
);

  localparam int NBytesHi = ShiftW / 8;
  localparam int NBytesLo = (bchpe_pkg::FieldDegree * bchpe_pkg::LowStrength + 7) / 8;
  localparam int CntW     = $clog2(NBytesHi + 1);

  logic [ShiftW-1:0] sh_q, sh_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              is_last;
  logic              take;
  logic              load;

  assign is_last     = (cnt_q == CntW'(1));
  assign take        = busy_q && out_ready_i;
  assign load        = pop_valid_i && (!busy_q || (take && is_last));
  assign pop_ready_o = !busy_q || (take && is_last);

  assign out_valid_o = busy_q;
  assign out_data_o  = sh_q[ShiftW-1 -: 8];
  assign out_last_o  = is_last;

  always_comb begin
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (load) begin
      sh_d   = pop_parity_i;
      cnt_d  = (pop_strength_i == bchpe_pkg::StrHigh) ? CntW'(NBytesHi) : CntW'(NBytesLo);
      busy_d = 1'b1;
    end else if (take) begin
      sh_d   = sh_q << 8;
      cnt_d  = cnt_q - CntW'(1);
      busy_d = !is_last;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

endmodule

/* rtl/bch_parity_encoder_top.sv */
// ----------------------------------------------------------------------------
// bch_parity_encoder_top
// Binary BCH parity encoder over GF(2^13) for 4- or 8-bit correction.
// A last byte's remainder passes the queue, then the output shift register.
// Throughput: one data byte per cycle in and one parity byte per cycle out,
// with a two-entry remainder queue letting both sides stall independently.
// Reset clears the remainder, the queue and the output; strength resets low.
// ----------------------------------------------------------------------------
//
// Data bytes are divided by the generator polynomial in a byte-wide LFSR
// (front). When a byte flagged by s_axis_tlast arrives it is absorbed, and the
// resulting remainder is pushed into the queue while the LFSR clears for the
// next message. The back end pops one remainder at a time and streams it out
// as 7 (4-bit strength) or 13 (8-bit strength) bytes, MSB first; the final
// byte is flagged by m_axis_tlast and any unused low bits in it are zero.
// A queued next codeword follows the previous one without a gap.
//
// s_axis_tready drops only while the queue is full, which happens when short
// messages arrive faster than their parity can be shifted out. A write to the
// strength register also clears the LFSR, so a new message starts under the
// new setting. The generator polynomials are computed at elaboration.
module bch_parity_encoder_top #(
  parameter int MaxStrength = bchpe_pkg::MaxStrengthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Strength register: 0 selects 4-bit correction, 1 the maximum strength.
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // Message byte requests.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  // Parity byte requests.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] parity_byte
  output logic       m_axis_tlast    // parity_last
);

  // Parity register width rounded up to whole bytes.
  localparam int ShiftW = ((bchpe_pkg::FieldDegree * MaxStrength + 7) / 8) * 8;

  logic                 push_valid;
  logic                 push_ready;
  logic [ShiftW-1:0]    push_parity;
  bchpe_pkg::strength_e push_strength;

  logic                 pop_valid;
  logic                 pop_ready;
  logic [ShiftW:0]      pop_data;

  bchpe_front #(
    .MaxStrength (MaxStrength),
    .ShiftW      (ShiftW)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_data_i       (s_axis_tdata),
    .in_last_i       (s_axis_tlast),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_parity_o   (push_parity),
    .push_strength_o (push_strength)
  );

  // Each queue entry carries the strength in its top bit above the parity.
  bchpe_queue #(
    .Width (ShiftW + 1)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  ({push_strength, push_parity}),
    .rd_valid_o (pop_valid),
    .rd_ready_i (pop_ready),
    .rd_data_o  (pop_data)
  );

  bchpe_back #(
    .MaxStrength (MaxStrength),
    .ShiftW      (ShiftW)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_parity_i   (pop_data[ShiftW-1:0]),
    .pop_strength_i (bchpe_pkg::strength_e'(pop_data[ShiftW])),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata),
    .out_last_o     (m_axis_tlast)
  );

endmodule

/* bench/bch_parity_encoder_top_tb.sv */
// ----------------------------------------------------------------------------
// bch_parity_encoder_top_tb
// Self-checking bench for the GF(2^13) BCH parity encoder.
// Message bytes are streamed in on the slave side. An independent bit-serial
// model of the remainder division predicts the 7 or 13 parity bytes of every
// codeword, and each parity byte taken from the master side is compared with
// the oldest prediction. A short table of directed messages runs first. Random
// messages of mixed length follow under both strengths and three idle patterns.
// ----------------------------------------------------------------------------
module bch_parity_encoder_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GfOrder    = 8191;
  localparam int RemWidth   = bchpe_pkg::MaxDeg;
  localparam int StallLimit = 2000;
  localparam int NumDirRows = 24;
  localparam int ChunkItems = 65;

  // One parity byte as it should leave the encoder.
  typedef struct packed {
    logic [7:0] pbyte;
    logic       last;
  } parity_t;

  // One row of the directed message table. A row can first rewrite the
  // strength register. It can also say that its codeword must be all zero
  // parity, which is known without any division.
  typedef struct packed {
    logic                  wr_cfg;
    bchpe_pkg::strength_e  str;
    logic [7:0]            data;
    logic                  last;
    logic                  zero_par;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  bch_parity_encoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Field tables and generator polynomials, built once at time zero.
  int unsigned field_pow [GfOrder];
  int unsigned field_log [GfOrder+1];
  bit          coset_member [GfOrder];
  int unsigned gen_coef [RemWidth+1];
  int unsigned gen_next [RemWidth+1];
  logic [RemWidth-1:0] gen_taps [2];
  int                  gen_degree [2];

  // Predicted encoder state.
  logic [RemWidth-1:0]  lfsr_rem;
  bchpe_pkg::strength_e cur_str;
  parity_t              parity_q [$];

  int mismatch_count = 0;
  int stall_cycles   = 0;
  int src_idle_pct   = 28;
  int snk_idle_pct   = 46;
  // Set while a directed row whose parity is known to be all zero is offered.
  logic typed_zero = 1'b0;

  stim_row_t dir_rows [NumDirRows] = '{
    // Right after reset the strength is low; a zero message has zero parity.
    '{1'b0, bchpe_pkg::StrLow,  8'h00, 1'b1, 1'b1},
    '{1'b0, bchpe_pkg::StrLow,  8'hFF, 1'b1, 1'b0},
    '{1'b0, bchpe_pkg::StrLow,  8'h80, 1'b0, 1'b0},
    '{1'b0, bchpe_pkg::StrLow,  8'h00, 1'b0, 1'b0},
    '{1'b0, bchpe_pkg::StrLow,  8'h01, 1'b1, 1'b0},
    // High strength: 13 zero bytes for a zero message.
    '{1'b1, bchpe_pkg::StrHigh, 8'h00, 1'b1, 1'b1},
    '{1'b0, bchpe_pkg::StrHigh, 8'hFF, 1'b1, 1'b0},
    // A single one walking through every bit position of the data byte.
    '{1'b0, bchpe_pkg::StrHigh, 8'h01, 1'b0, 1'b0},
    '{1'b0, bchpe_pkg::StrHigh, 8'h02, 1'b0, 1'b0},
    '{1'b0, bchpe_pkg::StrHigh, 8'h04, 1'b0, 1'b0},
    '{1'b0, bchpe_pkg::StrHigh, 8'h08, 1'b0, 1'b0},
    '{1'b0, bchpe_pkg::StrHigh, 8'h10, 1'b0, 1'b0},
    '{1'b0, bchpe_pkg::StrHigh, 8'h20, 1'b0, 1'b0},
    '{1'b0, bchpe_pkg::StrHigh, 8'h40, 1'b0, 1'b0},
    '{1'b0, bchpe_pkg::StrHigh, 8'h80, 1'b1, 1'b0},
    '{1'b0, bchpe_pkg::StrHigh, 8'hFF, 1'b0, 1'b0},
    '{1'b0, bchpe_pkg::StrHigh, 8'hFF, 1'b0, 1'b0},
    '{1'b0, bchpe_pkg::StrHigh, 8'hFF, 1'b1, 1'b0},
    // A half message is dropped by the strength write that follows it.
    '{1'b0, bchpe_pkg::StrHigh, 8'hAA, 1'b0, 1'b0},
    '{1'b0, bchpe_pkg::StrHigh, 8'h55, 1'b0, 1'b0},
    '{1'b1, bchpe_pkg::StrLow,  8'h00, 1'b1, 1'b1},
    '{1'b0, bchpe_pkg::StrLow,  8'hA5, 1'b0, 1'b0},
    '{1'b1, bchpe_pkg::StrHigh, 8'h00, 1'b1, 1'b1},
    '{1'b0, bchpe_pkg::StrHigh, 8'h5A, 1'b1, 1'b0}
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned field_mul(int unsigned a, int unsigned b);
    if (a == 0 || b == 0) begin
      return 0;
    end
    return field_pow[(field_log[a] + field_log[b]) % GfOrder];
  endfunction

  // Generator for strength t: product of (x + alpha^e) over every root in the
  // cyclotomic cosets of alpha^1 .. alpha^2t. The leading term is dropped.
  task automatic build_generator(input int t, input int sel);
    int unsigned c;
    int unsigned r;
    int          len;
    for (int e = 0; e < GfOrder; e++) begin
      coset_member[e] = 1'b0;
    end
    for (int e = 1; e <= 2 * t; e++) begin
      c = e;
      do begin
        coset_member[c] = 1'b1;
        c = (c * 2) % GfOrder;
      end while (c != e);
    end
    for (int i = 0; i <= RemWidth; i++) begin
      gen_coef[i] = 0;
    end
    gen_coef[0] = 1;
    len = 1;
    for (int e = 0; e < GfOrder; e++) begin
      if (coset_member[e] && len <= RemWidth) begin
        r = field_pow[e];
        for (int i = 0; i <= RemWidth; i++) begin
          gen_next[i] = 0;
        end
        for (int i = 0; i < len; i++) begin
          gen_next[i]   = gen_next[i] ^ field_mul(gen_coef[i], r);
          gen_next[i+1] = gen_next[i+1] ^ gen_coef[i];
        end
        len++;
        gen_coef = gen_next;
      end
    end
    gen_degree[sel] = len - 1;
    gen_taps[sel]   = '0;
    for (int i = 0; i < len - 1; i++) begin
      gen_taps[sel][i] = gen_coef[i][0];
    end
  endtask

  // Shift one message byte, MSB first, through the remainder division.
  task automatic absorb_byte(input logic [7:0] d);
    int                  sel;
    int                  deg;
    logic                fb;
    logic [RemWidth-1:0] mask;
    sel  = (cur_str == bchpe_pkg::StrHigh) ? 1 : 0;
    deg  = gen_degree[sel];
    mask = '1;
    mask = mask >> (RemWidth - deg);
    for (int b = 7; b >= 0; b--) begin
      fb       = d[b] ^ lfsr_rem[deg-1];
      lfsr_rem = (lfsr_rem << 1) & mask;
      if (fb) begin
        lfsr_rem = lfsr_rem ^ gen_taps[sel];
      end
    end
  endtask

  // Queue the remainder as parity bytes, highest bits first, then clear it.
  // When the codeword is known to be all zero the bytes are queued as typed.
  task automatic queue_parity(input logic zero_known);
    int      deg;
    int      nbytes;
    int      pos;
    parity_t item;
    deg    = gen_degree[(cur_str == bchpe_pkg::StrHigh) ? 1 : 0];
    nbytes = (deg + 7) / 8;
    if (zero_known) begin
      nbytes = (cur_str == bchpe_pkg::StrHigh) ? 13 : 7;
    end
    for (int k = 0; k < nbytes; k++) begin
      item.pbyte = 8'h00;
      item.last  = (k == nbytes - 1);
      if (!zero_known) begin
        for (int b = 0; b < 8; b++) begin
          pos = k * 8 + b;
          if (pos < deg && lfsr_rem[deg-1-pos]) begin
            item.pbyte[7-b] = 1'b1;
          end
        end
      end
      parity_q.push_back(item);
    end
    lfsr_rem = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offer one message byte at a falling edge and hold it until the request is
  // taken. Returns at the falling edge after acceptance with tvalid still high.
  task automatic put_byte(input logic [7:0] d, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    @(negedge clk_i);
  endtask

  // Stop sending and let every predicted parity byte come out. A further wait
  // covers a data byte that is still being absorbed without a result.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (parity_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_strength(input bchpe_pkg::strength_e s);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= s;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random messages: many single-byte ones that fill the remainder queue,
  // many short ones and some longer ones. The final message of a chunk is cut
  // to the chunk size. A chunk may end on a half message, which the next
  // strength write must discard.
  task automatic send_messages(input int n_items);
    int         sent;
    int         len;
    logic [7:0] d;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0, 1, 2: len = 1;
        3, 4, 5, 6, 7: len = $urandom_range(16, 2);
        default: len = $urandom_range(40, 17);
      endcase
      if (len > n_items - sent) begin
        len = n_items - sent;
      end
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(7))
          0: d = 8'h00;
          1: d = 8'hFF;
          default: d = 8'($urandom_range(255));
        endcase
        put_byte(d, i == len - 1);
        sent++;
      end
    end
    if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(3, 1)) put_byte(8'($urandom_range(255)), 1'b0);
    end
  endtask

  // The receiver stalls at random; the rate follows the current phase.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Prediction and checking, both on the rising edge. A strength write clears
  // the remainder; an accepted last byte turns the remainder into parity.
  always @(posedge clk_i) begin
    parity_t want;
    if (rst_ni) begin
      if (cfg_we_i === 1'b1) begin
        cur_str  = bchpe_pkg::strength_e'(cfg_wdata_i);
        lfsr_rem = '0;
      end
      if (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) begin
        absorb_byte(s_axis_tdata);
        if (s_axis_tlast) begin
          queue_parity(typed_zero);
        end
      end
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        if (parity_q.size() == 0) begin
          report_mismatch($sformatf("parity byte %02h with nothing expected", m_axis_tdata));
        end else begin
          want = parity_q.pop_front();
          if (m_axis_tdata !== want.pbyte) begin
            report_mismatch($sformatf("parity byte %02h, expected %02h",
                                      m_axis_tdata, want.pbyte));
          end
          if (m_axis_tlast !== want.last) begin
            report_mismatch($sformatf("tlast %b on byte %02h, expected %b",
                                      m_axis_tlast, m_axis_tdata, want.last));
          end
        end
      end
    end
  end

  // Watchdog: too many cycles in a row without any request taken on either
  // side means the encoder has hung.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned          v;
    bchpe_pkg::strength_e first_str;
    // Exponent and log tables of GF(2^13), then both generators.
    v = 1;
    for (int i = 0; i < GfOrder; i++) begin
      field_pow[i] = v;
      field_log[v] = i;
      v = v << 1;
      if (v & (1 << bchpe_pkg::FieldDegree)) begin
        v = v ^ int'(bchpe_pkg::GfPoly);
      end
    end
    build_generator(bchpe_pkg::LowStrength, 0);
    build_generator(bchpe_pkg::MaxStrengthDef, 1);
    lfsr_rem = '0;
    cur_str  = bchpe_pkg::StrLow;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table.
    for (int r = 0; r < NumDirRows; r++) begin
      if (dir_rows[r].wr_cfg) begin
        write_strength(dir_rows[r].str);
      end
      typed_zero = dir_rows[r].zero_par;
      put_byte(dir_rows[r].data, dir_rows[r].last);
    end
    typed_zero = 1'b0;

    // Random part: three idle patterns, each run under both strengths in a
    // random order. Every strength write first drains the encoder.
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          src_idle_pct = 28;
          snk_idle_pct = 46;
        end
        1: begin
          src_idle_pct = 46;
          snk_idle_pct = 28;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      first_str = bchpe_pkg::strength_e'($urandom_range(1));
      write_strength(first_str);
      send_messages(ChunkItems);
      write_strength((first_str == bchpe_pkg::StrHigh) ? bchpe_pkg::StrLow
                                                       : bchpe_pkg::StrHigh);
      send_messages(ChunkItems);
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/bchpe_pkg.sv
rtl/bchpe_front.sv
rtl/bchpe_queue.sv
rtl/bchpe_back.sv
rtl/bch_parity_encoder_top.sv
bench/bch_parity_encoder_top_tb.sv
